// File: src/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types and constants for the vec4 matrix transform pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vmt_pkg;

    localparam int CW_DEFAULT      = 16;
    localparam int FB_DEFAULT      = 8;
    localparam int NUM_ROWS        = 4;
    localparam int NUM_COLS        = 4;
    localparam int ROW_WIDTH       = 64;
    localparam int CFG_INDEX_WIDTH = 8;

    localparam logic [ROW_WIDTH-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
    localparam logic [ROW_WIDTH-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
    localparam logic [ROW_WIDTH-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
    localparam logic [ROW_WIDTH-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;

    // register map of the configuration port
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MATRIX_ROW0 = 8'd0,
        REG_MATRIX_ROW1 = 8'd1,
        REG_MATRIX_ROW2 = 8'd2,
        REG_MATRIX_ROW3 = 8'd3
    } vmt_reg_t;

    // per-stage control travelling with each word
    typedef struct packed {
        logic valid;
        logic last;
    } vmt_ctl_t;

endpackage

`default_nettype wire

// File: src/vmt_cfg_regs.sv
// ----------------------------------------------------------------------------
// vmt_cfg_regs
// Matrix row registers and entry extraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmt_cfg_regs
    import vmt_pkg::*;
#(
    parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  wire logic [ROW_WIDTH-1:0]              cfg_data,
    output logic signed [COMPONENT_WIDTH-1:0]      entry [NUM_ROWS][NUM_COLS]
);

    logic [ROW_WIDTH-1:0] row_reg  [NUM_ROWS];
    logic [ROW_WIDTH-1:0] row_next [NUM_ROWS];

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            row_next[r] = row_reg[r];
        end
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MATRIX_ROW0: row_next[0] = cfg_data;
                REG_MATRIX_ROW1: row_next[1] = cfg_data;
                REG_MATRIX_ROW2: row_next[2] = cfg_data;
                REG_MATRIX_ROW3: row_next[3] = cfg_data;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= ROW0_RESET;
            row_reg[1] <= ROW1_RESET;
            row_reg[2] <= ROW2_RESET;
            row_reg[3] <= ROW3_RESET;
        end else begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                row_reg[r] <= row_next[r];
            end
        end
    end

    // column j sits at bit COMPONENT_WIDTH*j; bits past the top of a row read as zero
    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
        for (genvar j = 0; j < NUM_COLS; j++) begin : g_col
            for (genvar b = 0; b < COMPONENT_WIDTH; b++) begin : g_bit
                localparam int IDX = COMPONENT_WIDTH * j + b;
                if (IDX < ROW_WIDTH) begin : g_in
                    assign entry[r][j][b] = row_reg[r][IDX];
                end else begin : g_out
                    assign entry[r][j][b] = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: src/vmt_mul_stage.sv
// ----------------------------------------------------------------------------
// vmt_mul_stage
// Stage 1: sixteen entry-by-component products, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmt_mul_stage
    import vmt_pkg::*;
#(
    parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire vmt_ctl_t                            in_ctl,
    output logic                                     in_ready,
    input  wire logic signed [COMPONENT_WIDTH-1:0]   vec [NUM_ROWS],
    input  wire logic signed [COMPONENT_WIDTH-1:0]   entry [NUM_ROWS][NUM_COLS],
    output vmt_ctl_t                                 out_ctl,
    input  wire logic                                out_ready,
    output logic signed [2*COMPONENT_WIDTH-1:0]      prod [NUM_ROWS][NUM_COLS]
);

    localparam int PROD_W = 2 * COMPONENT_WIDTH;

    vmt_ctl_t                  ctl_reg;
    logic signed [PROD_W-1:0]  prod_reg  [NUM_ROWS][NUM_COLS];
    logic signed [PROD_W-1:0]  prod_next [NUM_ROWS][NUM_COLS];

    assign in_ready = !ctl_reg.valid || out_ready;

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int j = 0; j < NUM_COLS; j++) begin
                prod_next[r][j] = PROD_W'(entry[r][j]) * PROD_W'(vec[r]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (in_ready) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_ctl.valid) begin
            prod_reg <= prod_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign prod    = prod_reg;

endmodule

`default_nettype wire

// File: src/vmt_add_stage.sv
// ----------------------------------------------------------------------------
// vmt_add_stage
// Stage 2: full-width column sums of the products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmt_add_stage
    import vmt_pkg::*;
#(
    parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire vmt_ctl_t                            in_ctl,
    output logic                                     in_ready,
    input  wire logic signed [2*COMPONENT_WIDTH-1:0] prod [NUM_ROWS][NUM_COLS],
    output vmt_ctl_t                                 out_ctl,
    input  wire logic                                out_ready,
    output logic signed [2*COMPONENT_WIDTH+1:0]      sum [NUM_COLS]
);

    // four products need two guard bits
    localparam int SUM_W = 2 * COMPONENT_WIDTH + 2;

    vmt_ctl_t                 ctl_reg;
    logic signed [SUM_W-1:0]  sum_reg  [NUM_COLS];
    logic signed [SUM_W-1:0]  sum_next [NUM_COLS];

    assign in_ready = !ctl_reg.valid || out_ready;

    always_comb begin
        for (int j = 0; j < NUM_COLS; j++) begin
            sum_next[j] = (SUM_W'(prod[0][j]) + SUM_W'(prod[1][j]))
                        + (SUM_W'(prod[2][j]) + SUM_W'(prod[3][j]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (in_ready) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_ctl.valid) begin
            sum_reg <= sum_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign sum     = sum_reg;

endmodule

`default_nettype wire

// File: src/vmt_sat_stage.sv
// ----------------------------------------------------------------------------
// vmt_sat_stage
// Stage 3: round half up, shift back to the component format, saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vmt_sat_stage
    import vmt_pkg::*;
#(
    parameter int COMPONENT_WIDTH = CW_DEFAULT,
    parameter int FRACTION_BITS   = FB_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire vmt_ctl_t                            in_ctl,
    output logic                                     in_ready,
    input  wire logic signed [2*COMPONENT_WIDTH+1:0] sum [NUM_COLS],
    output vmt_ctl_t                                 out_ctl,
    input  wire logic                                out_ready,
    output logic signed [COMPONENT_WIDTH-1:0]        comp [NUM_COLS],
    output logic                                     sat
);

    localparam int SUM_W = 2 * COMPONENT_WIDTH + 2;
    localparam int RND_W = SUM_W + 1;

    // half an LSB of the result; zero when there is no fraction
    localparam logic signed [RND_W-1:0] HALF = (RND_W'(1) << FRACTION_BITS) >> 1;
    localparam logic signed [RND_W-1:0] MAXV =
        {{(RND_W-COMPONENT_WIDTH+1){1'b0}}, {(COMPONENT_WIDTH-1){1'b1}}};
    localparam logic signed [RND_W-1:0] MINV =
        {{(RND_W-COMPONENT_WIDTH+1){1'b1}}, {(COMPONENT_WIDTH-1){1'b0}}};

    vmt_ctl_t                            ctl_reg;
    logic signed [COMPONENT_WIDTH-1:0]   comp_reg  [NUM_COLS];
    logic signed [COMPONENT_WIDTH-1:0]   comp_next [NUM_COLS];
    logic                                sat_reg;
    logic                                sat_next;
    logic signed [RND_W-1:0]             rnd [NUM_COLS];
    logic signed [RND_W-1:0]             q   [NUM_COLS];

    assign in_ready = !ctl_reg.valid || out_ready;

    always_comb begin
        sat_next = 1'b0;
        for (int j = 0; j < NUM_COLS; j++) begin
            rnd[j] = RND_W'(sum[j]) + HALF;
            q[j]   = rnd[j] >>> FRACTION_BITS;
            if (q[j] > MAXV) begin
                comp_next[j] = MAXV[COMPONENT_WIDTH-1:0];
                sat_next     = 1'b1;
            end else if (q[j] < MINV) begin
                comp_next[j] = MINV[COMPONENT_WIDTH-1:0];
                sat_next     = 1'b1;
            end else begin
                comp_next[j] = q[j][COMPONENT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (in_ready) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_ctl.valid) begin
            comp_reg <= comp_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign comp    = comp_reg;
    assign sat     = sat_reg;

endmodule

`default_nettype wire

// File: src/vec4_matrix_transform.sv
// ----------------------------------------------------------------------------
// vec4_matrix_transform
// Streams 4-component fixed-point vectors through a configurable 4x4 matrix.
// ----------------------------------------------------------------------------
// Each input word (x, y, z, w) is taken as a row vector and multiplied by the
// matrix in the four row registers: out[j] = sum over r of m[r][j] * in[r].
// Components and entries are signed fixed point, COMPONENT_WIDTH bits with
// FRACTION_BITS fractional (Q8.8 by default). Sums are kept at full width,
// rounded to nearest (ties upward), shifted back and saturated; m_tuser is
// set when any component was clipped. tlast passes through unchanged. After
// reset the matrix is the identity. The block takes one word per cycle while
// the output is ready. Each word passes through a multiply stage, a column-sum
// stage and a round/saturate stage, the last of which is the output register.
// Each stage refills as soon as it empties, so a back-pressured output only
// stalls the stages behind a full one. The configuration port is always ready;
// write it only while no word is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vec4_matrix_transform
    import vmt_pkg::*;
#(
    parameter int COMPONENT_WIDTH = CW_DEFAULT,
    parameter int FRACTION_BITS   = FB_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    // input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // vec_x, vec_y, vec_z, vec_w (low to high), zero padded to bytes
    input  wire logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    input  wire logic                                  s_tlast,   // last_in

    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // out_x, out_y, out_z, out_w (low to high), zero padded to bytes
    output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]     m_tdata,
    output logic                                       m_tuser,   // saturated
    output logic                                       m_tlast,   // last_out

    // configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]            cfg_index,
    input  wire logic [ROW_WIDTH-1:0]                  cfg_data
);

    localparam int CW     = COMPONENT_WIDTH;
    localparam int DATA_W = ((4 * CW + 7) / 8) * 8;

    logic signed [CW-1:0]     vec   [NUM_ROWS];
    logic signed [CW-1:0]     entry [NUM_ROWS][NUM_COLS];
    logic signed [2*CW-1:0]   prod  [NUM_ROWS][NUM_COLS];
    logic signed [2*CW+1:0]   sum   [NUM_COLS];
    logic signed [CW-1:0]     comp  [NUM_COLS];
    logic                     sat;

    vmt_ctl_t in_ctl, mul_ctl, add_ctl, sat_ctl;
    logic     mul_ready, add_ready, sat_ready;

    // unpack components, x lowest
    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_unpack
        assign vec[r] = s_tdata[r*CW +: CW];
    end

    assign in_ctl.valid = s_tvalid;
    assign in_ctl.last  = s_tlast;
    assign s_tready     = mul_ready;
    assign cfg_ready    = 1'b1;

    vmt_cfg_regs #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .entry     (entry)
    );

    vmt_mul_stage #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (in_ctl),
        .in_ready  (mul_ready),
        .vec       (vec),
        .entry     (entry),
        .out_ctl   (mul_ctl),
        .out_ready (add_ready),
        .prod      (prod)
    );

    vmt_add_stage #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH)
    ) u_add (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (mul_ctl),
        .in_ready  (add_ready),
        .prod      (prod),
        .out_ctl   (add_ctl),
        .out_ready (sat_ready),
        .sum       (sum)
    );

    vmt_sat_stage #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (add_ctl),
        .in_ready  (sat_ready),
        .sum       (sum),
        .out_ctl   (sat_ctl),
        .out_ready (m_tready),
        .comp      (comp),
        .sat       (sat)
    );

    assign m_tvalid = sat_ctl.valid;
    assign m_tlast  = sat_ctl.last;
    assign m_tuser  = sat;
    assign m_tdata  = DATA_W'({comp[3], comp[2], comp[1], comp[0]});

    // words held in the pipeline
    logic       s_fire, m_fire;
    logic [1:0] occ;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign occ    = 2'(mul_ctl.valid) + 2'(add_ctl.valid) + 2'(sat_ctl.valid);

`ifndef ASSERT_OFF
    // a word in with none out grows the occupancy by one
    a_occ_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !m_fire) |=> (occ == $past(occ) + 2'd1))
        else $error("word lost or duplicated on entry");

    // a word out with none in shrinks it by one
    a_occ_shrink: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_fire && m_fire) |=> (occ == $past(occ) - 2'd1))
        else $error("word lost or duplicated on exit");

    // one in and one out, or neither, leaves it unchanged
    a_occ_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire == m_fire) |=> (occ == $past(occ)))
        else $error("occupancy changed without traffic");

    // a clipped word carries at least one full-scale component
    a_sat_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (comp[0] == {1'b0, {(CW-1){1'b1}}} || comp[0] == {1'b1, {(CW-1){1'b0}}} ||
             comp[1] == {1'b0, {(CW-1){1'b1}}} || comp[1] == {1'b1, {(CW-1){1'b0}}} ||
             comp[2] == {1'b0, {(CW-1){1'b1}}} || comp[2] == {1'b1, {(CW-1){1'b0}}} ||
             comp[3] == {1'b0, {(CW-1){1'b1}}} || comp[3] == {1'b1, {(CW-1){1'b0}}}))
        else $error("saturation flag without a clipped component");
`endif

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vec4 matrix transform stream block.
// ----------------------------------------------------------------------------
// Loads a series of matrices through the configuration port, streams vectors
// in, and checks every output word against an in-bench fixed-point model of
// the row-vector times matrix product (round half up, saturate to Q8.8).
// Opens with directed words (identity after reset, saturation in both
// directions, rounding ties, writes to unmapped indexes), then random phases
// with a fresh matrix each. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import vmt_pkg::*;

    localparam int CW           = CW_DEFAULT;
    localparam int FRAC         = FB_DEFAULT;
    localparam int DATA_W       = ((4 * CW + 7) / 8) * 8;
    localparam int PIPE_LATENCY = 3;
    localparam int IDLE_LIMIT   = 2000;
    localparam int N_PHASES     = 8;
    localparam int PHASE_WORDS  = 54;

    typedef struct packed {
        logic [3:0][CW-1:0] comp;
        logic               sat;
        logic               last;
    } vec_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: holds the matrix copy and the queue of predicted words
    // ------------------------------------------------------------------------
    class transform_scoreboard;
        logic [ROW_WIDTH-1:0] rows [NUM_ROWS];
        vec_result_t          predicted_q [$];
        int unsigned          n_errors;
        int unsigned          n_checked;
        int unsigned          n_sat;
        int unsigned          n_last;

        function new();
            rows[0] = ROW0_RESET;
            rows[1] = ROW1_RESET;
            rows[2] = ROW2_RESET;
            rows[3] = ROW3_RESET;
        endfunction

        function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [ROW_WIDTH-1:0] val);
            case (idx)
                REG_MATRIX_ROW0: rows[0] = val;
                REG_MATRIX_ROW1: rows[1] = val;
                REG_MATRIX_ROW2: rows[2] = val;
                REG_MATRIX_ROW3: rows[3] = val;
                default: ;
            endcase
        endfunction

        // out[j] = sum_r m[r][j] * in[r], rounded half up, shifted, saturated
        function vec_result_t transform(logic [DATA_W-1:0] vec, logic last);
            vec_result_t      res;
            longint           acc;
            logic signed [CW-1:0] ent;
            logic signed [CW-1:0] cmp;
            res = '0;
            for (int j = 0; j < NUM_COLS; j++) begin
                acc = 0;
                for (int r = 0; r < NUM_ROWS; r++) begin
                    ent = rows[r][CW*j +: CW];
                    cmp = vec[CW*r +: CW];
                    acc += longint'(ent) * longint'(cmp);
                end
                acc = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
                if (acc > 32767) begin
                    res.comp[j] = 16'h7fff;
                    res.sat     = 1'b1;
                end else if (acc < -32768) begin
                    res.comp[j] = 16'h8000;
                    res.sat     = 1'b1;
                end else begin
                    res.comp[j] = acc[CW-1:0];
                end
            end
            res.last = last;
            return res;
        endfunction

        function void note_input(logic [DATA_W-1:0] vec, logic last);
            predicted_q.push_back(transform(vec, last));
        endfunction

        task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
            $display("ERROR %s: got %h, want %h", what, got, want);
            n_errors++;
        endtask

        task check_result(logic [DATA_W-1:0] data, logic sat, logic last);
            vec_result_t want;
            n_checked++;
            if (predicted_q.size() == 0) begin
                report_mismatch("word with none pending", data, '0);
                return;
            end
            want = predicted_q.pop_front();
            for (int j = 0; j < NUM_COLS; j++)
                if (data[CW*j +: CW] !== want.comp[j])
                    report_mismatch($sformatf("component %0d", j), data[CW*j +: CW],
                                    want.comp[j]);
            if (sat !== want.sat)
                report_mismatch("saturated flag", sat, want.sat);
            if (last !== want.last)
                report_mismatch("tlast", last, want.last);
            if (want.sat)
                n_sat++;
            if (want.last)
                n_last++;
        endtask

        function int pending();
            return predicted_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block signals; those the bench drives are known from time zero
    // ------------------------------------------------------------------------
    logic                       aclk;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [DATA_W-1:0]          s_tdata   = '0;   // vec_x, vec_y, vec_z, vec_w
    logic                       s_tlast   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [DATA_W-1:0]          m_tdata;          // out_x, out_y, out_z, out_w
    logic                       m_tuser;          // saturated
    logic                       m_tlast;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [ROW_WIDTH-1:0]       cfg_data  = '0;

    transform_scoreboard sb = new();
    bit          no_idle     = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned n_loads     = 0;
    int unsigned n_unmapped  = 0;

    vec4_matrix_transform dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int unsigned rand_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CW-1:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h0100;
            4: return 16'hff00;
            5: return 16'h0001;
            default: return 16'hffff;
        endcase
    endfunction

    // style 0: any value, 1: small magnitude, 2: extremes and unit steps
    function automatic logic [CW-1:0] rand_comp(int style, int unsigned span);
        case (style)
            0: return CW'($urandom);
            1: return CW'($urandom_range(0, 2 * span) - span);
            default: return pick_extreme();
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pack_vec(logic [CW-1:0] x, logic [CW-1:0] y,
                                                   logic [CW-1:0] z, logic [CW-1:0] w);
        return {w, z, y, x};
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // valid is left high on return; the caller lowers it at the end of a burst
    task automatic push_vec(logic [DATA_W-1:0] vec, logic last);
        int unsigned gap;
        gap = rand_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vec;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stop_stream();
        s_tvalid <= 1'b0;
    endtask

    task automatic cfg_write(logic [CFG_INDEX_WIDTH-1:0] idx, logic [ROW_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_matrix(logic [ROW_WIDTH-1:0] r0, logic [ROW_WIDTH-1:0] r1,
                               logic [ROW_WIDTH-1:0] r2, logic [ROW_WIDTH-1:0] r3);
        cfg_write(REG_MATRIX_ROW0, r0);
        cfg_write(REG_MATRIX_ROW1, r1);
        cfg_write(REG_MATRIX_ROW2, r2);
        cfg_write(REG_MATRIX_ROW3, r3);
        cfg_valid <= 1'b0;
        n_loads++;
    endtask

    // writes beyond the row registers must leave the matrix alone;
    // valid is left high, the caller lowers it after its last write
    task automatic stray_write();
        cfg_write(CFG_INDEX_WIDTH'(REG_MATRIX_ROW3) + CFG_INDEX_WIDTH'($urandom_range(1, 252)),
                  {$urandom, $urandom});
        n_unmapped++;
    endtask

    // first edge lets the monitor record the final accepted word
    task automatic wait_drained();
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 1) @(posedge aclk);
    endtask

    task automatic run_random_phase(int unsigned n_words);
        logic [ROW_WIDTH-1:0] r [NUM_ROWS];
        int                   mstyle;
        int                   vstyle;
        int unsigned          pick;
        mstyle = $urandom_range(0, 2);
        for (int i = 0; i < NUM_ROWS; i++)
            for (int j = 0; j < NUM_COLS; j++)
                r[i][CW*j +: CW] = rand_comp(mstyle, 384);
        if ($urandom_range(0, 3) == 0)
            stray_write();
        load_matrix(r[0], r[1], r[2], r[3]);
        for (int n = 0; n < n_words; n++) begin
            pick   = $urandom_range(0, 9);
            vstyle = (pick < 5) ? 0 : (pick < 8) ? 1 : 2;
            push_vec(pack_vec(rand_comp(vstyle, 1024), rand_comp(vstyle, 1024),
                              rand_comp(vstyle, 1024), rand_comp(vstyle, 1024)),
                     $urandom_range(0, 7) == 0);
        end
        stop_stream();
        wait_drained();
    endtask

    // output back-pressure: random stalls between runs of ready
    initial begin
        int unsigned stall;
        int unsigned run;
        @(posedge aclk);
        forever begin
            stall = rand_gap();
            run   = $urandom_range(1, 20);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // monitors and watchdog; sampled values are those before the edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity after reset: words come back unchanged
        push_vec(pack_vec(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0);
        push_vec(pack_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 1'b0);
        push_vec(pack_vec(16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1);
        push_vec(pack_vec(16'h7fff, 16'h8000, 16'h0001, 16'hffff), 1'b0);
        push_vec(pack_vec(16'h0100, 16'hff00, 16'h1234, 16'hedcb), 1'b1);
        stop_stream();
        wait_drained();

        // all entries at the positive limit: clips both ways
        load_matrix({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
        push_vec(pack_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 1'b0);
        push_vec(pack_vec(16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b1);
        push_vec(pack_vec(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0);
        push_vec(pack_vec(16'h0001, 16'hffff, 16'h0001, 16'hffff), 1'b0);
        stop_stream();
        wait_drained();

        // all entries at the negative limit; -128.0 * 1.0 lands exactly on the floor
        load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
        push_vec(pack_vec(16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0);
        push_vec(pack_vec(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 1'b0);
        push_vec(pack_vec(16'h0100, 16'h0000, 16'h0000, 16'h0000), 1'b1);
        push_vec(pack_vec(16'h0100, 16'h0001, 16'h0000, 16'h0000), 1'b0);
        stop_stream();
        wait_drained();

        // diagonal of one LSB: exercises rounding, ties go upward
        load_matrix(64'h0000_0000_0000_0001, 64'h0000_0000_0001_0000,
                    64'h0000_0001_0000_0000, 64'h0001_0000_0000_0000);
        push_vec(pack_vec(16'h0080, 16'hff80, 16'h007f, 16'hff7f), 1'b0);
        push_vec(pack_vec(16'h7fff, 16'h8000, 16'h0180, 16'hfe80), 1'b1);
        stop_stream();
        wait_drained();

        // unmapped indexes: matrix must stay as it was
        stray_write();
        cfg_write(REG_MATRIX_ROW3 | 8'hfc, {$urandom, $urandom});
        cfg_valid <= 1'b0;
        n_unmapped++;
        push_vec(pack_vec(16'h0080, 16'hff80, 16'h007f, 16'hff7f), 1'b1);
        push_vec(pack_vec(16'h5555, 16'haaaa, 16'h3c3c, 16'hc3c3), 1'b0);
        stop_stream();
        wait_drained();

        // random phases, the first without any idling
        for (int p = 0; p < N_PHASES; p++) begin
            no_idle = (p == 0);
            run_random_phase(PHASE_WORDS);
        end
        no_idle = 1'b0;

        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch("words never returned", sb.pending(), 0);

        $display("Checked %0d words: %0d saturated, %0d with tlast", sb.n_checked, sb.n_sat,
                 sb.n_last);
        $display("Matrix loaded %0d times, %0d writes to unmapped indexes", n_loads,
                 n_unmapped);
        if (sb.n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
